// ===== sv/tbde_pkg.sv =====
// Shared types, constants and register codes for the two-button debouncer.
package tbde_pkg;

	localparam int TIME_W     = 32;
	localparam int CFG_TIME_W = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int EV_W       = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME         = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_DOWN_ENABLE  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DOWN_ENABLE = 8'd3;

	// register reset values
	localparam logic [CFG_TIME_W-1:0] DEBOUNCE_TIME_RST = 16'd25;
	localparam logic [CFG_TIME_W-1:0] HOLD_TIME_RST     = 16'd600;
	localparam logic LEFT_DOWN_ENABLE_RST  = 1'b0;
	localparam logic RIGHT_DOWN_ENABLE_RST = 1'b1;

	// result event codes
	localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EV_W-1:0] EV_L_PRESS = 3'd1;
	localparam logic [EV_W-1:0] EV_L_HOLD  = 3'd2;
	localparam logic [EV_W-1:0] EV_L_DOWN  = 3'd3;
	localparam logic [EV_W-1:0] EV_R_PRESS = 3'd4;
	localparam logic [EV_W-1:0] EV_R_HOLD  = 3'd5;
	localparam logic [EV_W-1:0] EV_R_DOWN  = 3'd6;

	// per-button event kind
	typedef logic [1:0] btn_kind_t;
	localparam btn_kind_t BTN_NONE  = 2'd0;
	localparam btn_kind_t BTN_PRESS = 2'd1;
	localparam btn_kind_t BTN_HOLD  = 2'd2;
	localparam btn_kind_t BTN_DOWN  = 2'd3;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [CFG_TIME_W-1:0] debounce_time;
		logic [CFG_TIME_W-1:0] hold_time;
		logic                  left_down_enable;
		logic                  right_down_enable;
	} cfg_t;

endpackage

// ===== sv/tbde_if.sv =====
// Channel interfaces: poll input, event result and configuration write.
interface tbde_poll_if;
	import tbde_pkg::*;
	logic              valid;
	logic              ready;
	logic              raw_left;
	logic              raw_right;
	logic [TIME_W-1:0] now_ms;
	modport source (output valid, output raw_left, output raw_right, output now_ms,
		input ready);
	modport sink (input valid, input raw_left, input raw_right, input now_ms,
		output ready);
endinterface

interface tbde_res_if;
	import tbde_pkg::*;
	logic            valid;
	logic            ready;
	logic [EV_W-1:0] event_res;
	modport source (output valid, output event_res, input ready);
	modport sink (input valid, input event_res, output ready);
endinterface

interface tbde_cfg_if;
	import tbde_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/tbde_cfg.sv =====
// Configuration register file.
module tbde_cfg import tbde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tbde_cfg_if.sink   cfg,
	output cfg_t       cfg_regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = regs_q;

	// register write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_time     <= DEBOUNCE_TIME_RST;
			regs_q.hold_time         <= HOLD_TIME_RST;
			regs_q.left_down_enable  <= LEFT_DOWN_ENABLE_RST;
			regs_q.right_down_enable <= RIGHT_DOWN_ENABLE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEBOUNCE_TIME:     regs_q.debounce_time     <= cfg.data;
				REG_HOLD_TIME:         regs_q.hold_time         <= cfg.data;
				REG_LEFT_DOWN_ENABLE:  regs_q.left_down_enable  <= cfg.data[0];
				REG_RIGHT_DOWN_ENABLE: regs_q.right_down_enable <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/tbde_btn.sv =====
// One button: debounce state, press/hold/down decision and state update.
module tbde_btn import tbde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  raw,
	input  logic [TIME_W-1:0]     now,
	input  logic [CFG_TIME_W-1:0] debounce_time,
	input  logic [CFG_TIME_W-1:0] hold_time,
	input  logic                  down_en,
	output btn_kind_t             kind
);

	logic              raw_q;
	logic              stable_q;
	logic [TIME_W-1:0] change_q;
	logic [TIME_W-1:0] press_q;
	logic              hold_q;

	logic [TIME_W-1:0] change_n;
	logic [TIME_W-1:0] press_n;
	logic [TIME_W-1:0] deb_el;
	logic [TIME_W-1:0] hold_el;
	logic              stable_n;
	logic              hold_n;
	logic              accept;

	// decide the event and the next state for this poll
	always_comb begin
		change_n = (raw != raw_q) ? now : change_q;
		deb_el   = now - change_n;
		hold_el  = now - press_q;
		accept   = (deb_el >= {{(TIME_W-CFG_TIME_W){1'b0}}, debounce_time}) &&
			(stable_q != raw);
		stable_n = stable_q;
		press_n  = press_q;
		hold_n   = hold_q;
		kind     = BTN_NONE;
		if (accept) begin
			stable_n = raw;
			if (!raw) begin
				// new press: restart the hold timer, hold check skipped
				press_n = now;
				hold_n  = 1'b0;
				kind    = down_en ? BTN_DOWN : BTN_NONE;
			end else if (!hold_q) begin
				kind = BTN_PRESS;
			end
		end else if (!stable_q && !hold_q &&
			(hold_el >= {{(TIME_W-CFG_TIME_W){1'b0}}, hold_time})) begin
			hold_n = 1'b1;
			kind   = BTN_HOLD;
		end
	end

	// state update, only when this button is sampled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b1;
			stable_q <= 1'b1;
			change_q <= '0;
			press_q  <= '0;
			hold_q   <= 1'b0;
		end else if (step) begin
			raw_q    <= raw;
			stable_q <= stable_n;
			change_q <= change_n;
			press_q  <= press_n;
			hold_q   <= hold_n;
		end
	end

	// a hold can only be flagged while the debounced level is pressed
	a_hold_while_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hold_q) |-> !stable_q)
		else $error("hold flag set while released");

	// state is frozen on polls where this button is skipped
	a_frozen_when_skipped: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable({raw_q, stable_q, hold_q, change_q, press_q}))
		else $error("button state changed without a step");

	// a debounced press starts the hold timer at the poll time
	a_press_start: assert property (@(posedge clk) disable iff (!arst_n)
		(step && accept && !raw) |=> (press_q == $past(now)) && !hold_q)
		else $error("press start not captured");

endmodule

// ===== sv/tbde_core.sv =====
// Poll register, left/right button evaluation and result register.
module tbde_core import tbde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg_regs,
	tbde_poll_if.sink  poll,
	tbde_res_if.source res
);

	logic              valid_s1;
	logic              raw_left_s1;
	logic              raw_right_s1;
	logic [TIME_W-1:0] now_s1;

	logic              out_valid_q;
	logic [EV_W-1:0]   event_q;

	logic              adv;
	logic              right_step;
	btn_kind_t         left_kind;
	btn_kind_t         right_kind;
	logic [EV_W-1:0]   event_n;

	// word moves from poll register to result register when the result slot frees
	assign adv        = valid_s1 && (!out_valid_q || res.ready);
	assign poll.ready = !valid_s1 || adv;
	assign right_step = adv && (left_kind == BTN_NONE);

	// poll register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			raw_left_s1  <= poll.raw_left;
			raw_right_s1 <= poll.raw_right;
			now_s1       <= poll.now_ms;
		end
	end

	tbde_btn u_left (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.raw           (raw_left_s1),
		.now           (now_s1),
		.debounce_time (cfg_regs.debounce_time),
		.hold_time     (cfg_regs.hold_time),
		.down_en       (cfg_regs.left_down_enable),
		.kind          (left_kind)
	);

	tbde_btn u_right (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (right_step),
		.raw           (raw_right_s1),
		.now           (now_s1),
		.debounce_time (cfg_regs.debounce_time),
		.hold_time     (cfg_regs.hold_time),
		.down_en       (cfg_regs.right_down_enable),
		.kind          (right_kind)
	);

	// left event wins; otherwise the right button's event
	always_comb begin
		case (left_kind)
			BTN_PRESS: event_n = EV_L_PRESS;
			BTN_HOLD:  event_n = EV_L_HOLD;
			BTN_DOWN:  event_n = EV_L_DOWN;
			default: begin
				case (right_kind)
					BTN_PRESS: event_n = EV_R_PRESS;
					BTN_HOLD:  event_n = EV_R_HOLD;
					BTN_DOWN:  event_n = EV_R_DOWN;
					default:   event_n = EV_NONE;
				endcase
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			event_q <= event_n;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.event_res = event_q;

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result lost after advance");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!poll.ready |-> (valid_s1 && out_valid_q && !res.ready))
		else $error("poll stalled without a full pipeline");

	a_left_priority: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && left_kind != BTN_NONE) |=>
		(event_q == EV_L_PRESS || event_q == EV_L_HOLD || event_q == EV_L_DOWN))
		else $error("left event not reported");

endmodule

// ===== sv/two_button_debounce_hold_events.sv =====
// Top level of the two-button debouncer with press, hold and down events.
//
//  channel | dir | payload                        | accepted when
//  poll    | in  | raw_left, raw_right, now_ms    | poll.valid && poll.ready
//  res     | out | event_res                      | res.valid && res.ready
//  cfg     | in  | index, data                    | cfg.valid && cfg.ready
//
//  One poll per clock while the result side keeps up: a poll is registered, both
//  buttons are evaluated from the poll register and the event lands in the result
//  register, one word per poll.
//  A stalled result holds the poll register; poll.ready drops only while both
//  are full. cfg.ready is always high.
//  Reset (arst_n low) clears button state to released and loads register defaults.
module two_button_debounce_hold_events import tbde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tbde_poll_if.sink  poll,
	tbde_res_if.source res,
	tbde_cfg_if.sink   cfg
);

	cfg_t cfg_regs;

	tbde_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	tbde_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.poll     (poll),
		.res      (res)
	);

endmodule

// ===== sim/tb_two_button_debounce_hold_events.sv =====
// Testbench for the two-button debouncer: random polls checked against a predictor.
module tb_two_button_debounce_hold_events;
	timeunit 1ns;
	timeprecision 1ps;
	import tbde_pkg::*;

	localparam int LEFT           = 0;
	localparam int RIGHT          = 1;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_HOLD_OFF  = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES     = 7;
	// first index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd4;

	// Predicts the event word for each poll and checks returned words in order.
	class event_scoreboard;
		logic [CFG_TIME_W-1:0] bounce_ms;
		logic [CFG_TIME_W-1:0] hold_ms;
		logic                  left_down_en;
		logic                  right_down_en;
		logic                  raw_seen [2];
		logic                  level [2];
		logic [TIME_W-1:0]     changed_at [2];
		logic [TIME_W-1:0]     pressed_at [2];
		logic                  hold_fired [2];
		logic [EV_W-1:0]       pending_events [$];
		int                    mismatches;
		int                    polls_seen;
		int                    events_checked;
		int                    settings_used;
		int                    event_tally [8];

		function new();
			bounce_ms     = DEBOUNCE_TIME_RST;
			hold_ms       = HOLD_TIME_RST;
			left_down_en  = LEFT_DOWN_ENABLE_RST;
			right_down_en = RIGHT_DOWN_ENABLE_RST;
			for (int k = 0; k < 2; k++) begin
				raw_seen[k]   = 1'b1;
				level[k]      = 1'b1;
				changed_at[k] = '0;
				pressed_at[k] = '0;
				hold_fired[k] = 1'b0;
			end
			for (int e = 0; e < 8; e++)
				event_tally[e] = 0;
			mismatches     = 0;
			polls_seen     = 0;
			events_checked = 0;
			settings_used  = 1;
		endfunction

		// register write; unmapped indexes are dropped
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DEBOUNCE_TIME:     bounce_ms     = data[CFG_TIME_W-1:0];
				REG_HOLD_TIME:         hold_ms       = data[CFG_TIME_W-1:0];
				REG_LEFT_DOWN_ENABLE:  left_down_en  = data[0];
				REG_RIGHT_DOWN_ENABLE: right_down_en = data[0];
				default: ;
			endcase
		endfunction

		// debounce and hold tracking of one button; time differences wrap
		function logic [EV_W-1:0] scan_button(int k, logic raw, logic [TIME_W-1:0] now,
				logic [EV_W-1:0] on_press, logic [EV_W-1:0] on_hold,
				logic [EV_W-1:0] on_down);
			logic [TIME_W-1:0] since_change;
			logic [TIME_W-1:0] since_press;
			if (raw != raw_seen[k]) begin
				changed_at[k] = now;
				raw_seen[k]   = raw;
			end
			since_change = now - changed_at[k];
			if (since_change >= bounce_ms && level[k] != raw_seen[k]) begin
				level[k] = raw_seen[k];
				if (level[k] == 1'b0) begin
					pressed_at[k] = now;
					hold_fired[k] = 1'b0;
					// a disabled down event still ends the scan of this button
					return on_down;
				end
				if (!hold_fired[k])
					return on_press;
			end
			since_press = now - pressed_at[k];
			if (level[k] == 1'b0 && !hold_fired[k] && since_press >= hold_ms) begin
				hold_fired[k] = 1'b1;
				return on_hold;
			end
			return EV_NONE;
		endfunction

		// left goes first; right is only scanned when left stays quiet
		function void note_poll(logic raw_l, logic raw_r, logic [TIME_W-1:0] now);
			logic [EV_W-1:0] ev;
			ev = scan_button(LEFT, raw_l, now, EV_L_PRESS, EV_L_HOLD,
				left_down_en ? EV_L_DOWN : EV_NONE);
			if (ev == EV_NONE)
				ev = scan_button(RIGHT, raw_r, now, EV_R_PRESS, EV_R_HOLD,
					right_down_en ? EV_R_DOWN : EV_NONE);
			pending_events.push_back(ev);
			polls_seen++;
			event_tally[ev]++;
		endfunction

		function void check_event(logic [EV_W-1:0] got);
			logic [EV_W-1:0] want;
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event word, expected none, actual %0d", $time, got);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				events_checked++;
				if (got !== want) begin
					$display("%0t: event_res mismatch, expected %0d, actual %0d",
						$time, want, got);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	tbde_poll_if poll_ch ();
	tbde_res_if  res_ch ();
	tbde_cfg_if  cfg_ch ();

	two_button_debounce_hold_events dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	event_scoreboard sb = new();

	int                idle_pct;
	int                stall_pct;
	int                burst_req;
	int                burst_ack;
	int                hold_left;
	int                quiet_cycles;
	logic              want_l;
	logic              want_r;
	logic [TIME_W-1:0] cur_ms;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (burst_req != burst_ack) begin
			burst_ack = burst_req;
			hold_left = LONG_HOLD_OFF;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// check every accepted event word
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_event(res_ch.event_res);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one poll word after random idle cycles; called and left at a falling edge
	task automatic send_poll(input logic raw_l, input logic raw_r, input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < idle_pct) begin
			poll_ch.valid <= 1'b0;
			@(negedge clk);
		end
		poll_ch.valid     <= 1'b1;
		poll_ch.raw_left  <= raw_l;
		poll_ch.raw_right <= raw_r;
		poll_ch.now_ms    <= now;
		do
			@(posedge clk);
		while (!poll_ch.ready);
		sb.note_poll(raw_l, raw_r, now);
		@(negedge clk);
	endtask

	// stop offering and wait until every event word has come back
	task automatic settle();
		poll_ch.valid <= 1'b0;
		while (sb.pending_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// full register setting, written only while the block is idle
	task automatic apply_setting(input int unsigned db, input int unsigned hold,
			input logic ld, input logic rd);
		settle();
		write_reg(REG_DEBOUNCE_TIME, db[CFG_DATA_W-1:0]);
		write_reg(REG_HOLD_TIME, hold[CFG_DATA_W-1:0]);
		// upper data bits are don't-care for the enables
		write_reg(REG_LEFT_DOWN_ENABLE, {15'($urandom), ld});
		write_reg(REG_RIGHT_DOWN_ENABLE, {15'($urandom), rd});
		write_reg(REG_UNMAPPED + CFG_IDX_W'($urandom_range(0, 251)), 16'($urandom));
		sb.settings_used++;
	endtask

	// random button sequences with time steps spanning debounce and hold, plus bounce and time jumps
	task automatic random_polls(input int count, input int hold_off_at);
		int          pick;
		int unsigned db_span;
		int unsigned hold_span;
		logic        raw_l;
		logic        raw_r;
		db_span   = sb.bounce_ms + 1;
		hold_span = sb.hold_ms + 1;
		for (int n = 0; n < count; n++) begin
			if (n == hold_off_at)
				burst_req <= burst_req + 1;
			pick = $urandom_range(99);
			if (pick < 3)
				cur_ms = $urandom;
			else if (pick < 5)
				cur_ms = cur_ms - $urandom_range(1, 50);
			else if (pick < 60)
				cur_ms = cur_ms + $urandom_range(0, db_span);
			else if (pick < 90)
				cur_ms = cur_ms + $urandom_range(0, (hold_span >> 2) + 1);
			else
				cur_ms = cur_ms + $urandom_range(0, db_span + hold_span);
			if ($urandom_range(5) == 0)
				want_l = ~want_l;
			if ($urandom_range(5) == 0)
				want_r = ~want_r;
			// occasional contact bounce
			raw_l = want_l ^ ($urandom_range(11) == 0);
			raw_r = want_r ^ ($urandom_range(11) == 0);
			send_poll(raw_l, raw_r, cur_ms);
		end
	endtask

	initial begin
		int phase_items [NUM_PHASES];
		phase_items = '{300, 250, 300, 250, 300, 250, 275};
		arst_n            = 1'b0;
		poll_ch.valid     = 1'b0;
		poll_ch.raw_left  = 1'b1;
		poll_ch.raw_right = 1'b1;
		poll_ch.now_ms    = '0;
		res_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_DEBOUNCE_TIME;
		cfg_ch.data       = '0;
		idle_pct          = 0;
		stall_pct         = 0;
		burst_req         = 0;
		burst_ack         = 0;
		hold_left         = 0;
		quiet_cycles      = 0;
		want_l            = 1'b1;
		want_r            = 1'b1;
		cur_ms            = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: left press without down word, right down, holds on both
		send_poll(1'b1, 1'b1, 32'd0);
		send_poll(1'b0, 1'b1, 32'd10);
		send_poll(1'b0, 1'b1, 32'd35);
		send_poll(1'b0, 1'b0, 32'd40);
		send_poll(1'b0, 1'b0, 32'd65);
		send_poll(1'b1, 1'b0, 32'd100);
		send_poll(1'b0, 1'b0, 32'd110);
		send_poll(1'b0, 1'b0, 32'd700);
		send_poll(1'b0, 1'b0, 32'd701);
		send_poll(1'b1, 1'b1, 32'd710);
		// release after hold stays silent
		send_poll(1'b1, 1'b1, 32'd735);
		send_poll(1'b0, 1'b1, 32'd800);
		send_poll(1'b0, 1'b1, 32'd825);
		send_poll(1'b1, 1'b1, 32'd830);
		send_poll(1'b1, 1'b1, 32'd855);
		send_poll(1'b1, 1'b0, 32'd860);
		send_poll(1'b1, 1'b0, 32'd885);
		send_poll(1'b1, 1'b1, 32'd890);
		send_poll(1'b1, 1'b1, 32'd915);
		// timestamp wrap, then a step backwards that looks like a long hold
		send_poll(1'b0, 1'b1, 32'hFFFF_FFF0);
		send_poll(1'b0, 1'b1, 32'h0000_0009);
		send_poll(1'b0, 1'b1, 32'h0000_0005);

		// zero debounce and hold times, left down word on
		apply_setting(0, 0, 1'b1, 1'b0);
		send_poll(1'b1, 1'b0, 32'hFFFF_FFFF);
		send_poll(1'b0, 1'b0, 32'h0000_0000);
		send_poll(1'b0, 1'b0, 32'h0000_0000);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: apply_setting(3, 20, 1'b1, 1'b1);
				1: apply_setting(0, 0, 1'b0, 1'b0);
				2: apply_setting(DEBOUNCE_TIME_RST, HOLD_TIME_RST, 1'b1, 1'b0);
				3: apply_setting(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
				4: apply_setting($urandom_range(0, 40), $urandom_range(0, 200),
					1'($urandom_range(1)), 1'($urandom_range(1)));
				5: apply_setting(1, 16'hFFFF, 1'b0, 1'b1);
				default: apply_setting($urandom_range(0, 500), $urandom_range(0, 3000),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			endcase
			// idling mix per phase: none, sender, receiver, both
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			if (ph == 3)
				cur_ms = 32'hFFFF_0000;
			random_polls(phase_items[ph], (ph == 4) ? 100 : -1);
		end

		settle();
		$display("Polls checked: %0d over %0d register settings, %0d event words compared.",
			sb.polls_seen, sb.settings_used, sb.events_checked);
		$display("Left press/hold/down %0d/%0d/%0d, right %0d/%0d/%0d, quiet polls %0d.",
			sb.event_tally[EV_L_PRESS], sb.event_tally[EV_L_HOLD], sb.event_tally[EV_L_DOWN],
			sb.event_tally[EV_R_PRESS], sb.event_tally[EV_R_HOLD], sb.event_tally[EV_R_DOWN],
			sb.event_tally[EV_NONE]);
		if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d event words missing",
				sb.mismatches, sb.pending_events.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
